[rtl/core/ipss_pkg.sv]
// Package for the incremental PID speed step core.
// Holds field widths, band thresholds, offsets and the stage-to-stage struct.
// No dependencies.
package ipss_pkg;

  localparam int GAIN_FRAC_BITS = 8;

  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int PDIF_W  = ERR_W + 1;
  localparam int D2_W    = ERR_W + 2;
  localparam int PROD_P_W = GAIN_W + 1 + PDIF_W;
  localparam int PROD_I_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W = GAIN_W + 1 + D2_W;
  localparam int SUM_W   = PROD_D_W + 2;
  localparam int OFF_W   = 10;
  localparam int OUT_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DER_GAIN  = 2'd3;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RESET = 16'd1280;
  localparam logic [GAIN_W-1:0] INT_GAIN_RESET  = 16'd102;
  localparam logic [GAIN_W-1:0] DER_GAIN_RESET  = 16'd0;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic MODE_PID  = 1'b0;
  localparam logic MODE_DAMP = 1'b1;

  localparam int BAND_100 = -100;
  localparam int BAND_80  = -80;
  localparam int BAND_70  = -70;
  localparam int BAND_50  = -50;
  localparam int BAND_30  = -30;
  localparam int BOOST_THRESHOLD = 50;

  localparam logic signed [OFF_W-1:0] OFF_PID_70   = -10'sd80;
  localparam logic signed [OFF_W-1:0] OFF_PID_50   = -10'sd50;
  localparam logic signed [OFF_W-1:0] OFF_PID_30   = -10'sd20;
  localparam logic signed [OFF_W-1:0] OFF_BOOST_HI = 10'sd170;
  localparam logic signed [OFF_W-1:0] OFF_BOOST_LO = 10'sd120;
  localparam logic signed [OFF_W-1:0] OFF_DAMP_100 = -10'sd400;
  localparam logic signed [OFF_W-1:0] OFF_DAMP_80  = -10'sd300;
  localparam logic signed [OFF_W-1:0] OFF_DAMP_50  = -10'sd250;
  localparam logic signed [OFF_W-1:0] OFF_DAMP_30  = -10'sd200;

  typedef struct packed {
    logic                        clear;
    logic signed [PROD_P_W-1:0]  prod_p;
    logic signed [PROD_I_W-1:0]  prod_i;
    logic signed [PROD_D_W-1:0]  prod_d;
    logic signed [OFF_W-1:0]     offset;
  } ipss_terms_t;

endpackage

[rtl/core/ipss_terms.sv]
// First stage of the speed step: error, difference terms, gain products and band offset.
// Holds the controller state (errors, last speed, boost flag). Depends on ipss_pkg.
module ipss_terms (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            operation,
  input  logic signed [ipss_pkg::SPEED_W-1:0] measured_speed,
  input  logic signed [ipss_pkg::SPEED_W-1:0] target_speed,
  input  logic                            loop_mode,
  input  logic [ipss_pkg::GAIN_W-1:0]     proportional_gain,
  input  logic [ipss_pkg::GAIN_W-1:0]     integral_gain,
  input  logic [ipss_pkg::GAIN_W-1:0]     derivative_gain,
  output ipss_pkg::ipss_terms_t           terms
);
  import ipss_pkg::*;

  logic signed [ERR_W-1:0]   last_error;
  logic signed [ERR_W-1:0]   previous_error;
  logic signed [SPEED_W-1:0] last_speed;
  logic                      boost_flag;
  logic                      boost_flag_next;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  accel;
  logic signed [PDIF_W-1:0] pterm;
  logic signed [D2_W-1:0]   d2;
  logic signed [GAIN_W:0]   kp_s;
  logic signed [GAIN_W:0]   ki_s;
  logic signed [GAIN_W:0]   kd_s;
  logic signed [OFF_W-1:0]  offset;
  logic signed [31:0]       err_i;

  always_comb begin
    err   = ERR_W'(target_speed) - ERR_W'(measured_speed);
    accel = ERR_W'(measured_speed) - ERR_W'(last_speed);
    if (loop_mode == MODE_DAMP) begin
      pterm = -PDIF_W'(accel);
    end else begin
      pterm = PDIF_W'(err) - PDIF_W'(last_error);
    end
    d2 = D2_W'(err) - (D2_W'(last_error) <<< 1) + D2_W'(previous_error);
    kp_s = {1'b0, proportional_gain};
    ki_s = {1'b0, integral_gain};
    kd_s = {1'b0, derivative_gain};
    err_i = 32'(err);
  end

  always_comb begin
    offset = '0;
    boost_flag_next = boost_flag;
    if (loop_mode == MODE_PID) begin
      if (err_i < BAND_70) begin
        offset = OFF_PID_70;
        boost_flag_next = 1'b1;
      end else if (err_i < BAND_50) begin
        offset = OFF_PID_50;
        boost_flag_next = 1'b1;
      end else if (err_i < BAND_30) begin
        offset = OFF_PID_30;
        boost_flag_next = 1'b1;
      end else if (err_i > BOOST_THRESHOLD) begin
        if (boost_flag) begin
          offset = OFF_BOOST_HI;
          boost_flag_next = 1'b0;
        end else begin
          offset = OFF_BOOST_LO;
        end
      end
    end else begin
      if (err_i < BAND_100) begin
        offset = OFF_DAMP_100;
      end else if (err_i < BAND_80) begin
        offset = OFF_DAMP_80;
      end else if (err_i < BAND_50) begin
        offset = OFF_DAMP_50;
      end else if (err_i < BAND_30) begin
        offset = OFF_DAMP_30;
      end
    end
  end

  always_comb begin
    terms.clear  = (operation == OP_CLEAR);
    terms.prod_p = PROD_P_W'(kp_s) * PROD_P_W'(pterm);
    terms.prod_i = PROD_I_W'(ki_s) * PROD_I_W'(err);
    terms.prod_d = PROD_D_W'(kd_s) * PROD_D_W'(d2);
    terms.offset = offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error     <= '0;
      previous_error <= '0;
      last_speed     <= '0;
      boost_flag     <= 1'b0;
    end else if (advance) begin
      if (operation == OP_CLEAR) begin
        last_error     <= '0;
        previous_error <= '0;
        last_speed     <= '0;
        boost_flag     <= 1'b0;
      end else begin
        previous_error <= last_error;
        last_error     <= err;
        if (loop_mode == MODE_DAMP) begin
          last_speed <= measured_speed;
        end else begin
          boost_flag <= boost_flag_next;
        end
      end
    end
  end

endmodule

[rtl/core/ipss_finish.sv]
// Second stage of the speed step: sums the products, truncates toward zero,
// adds the band offset and saturates to 32 bits. Depends on ipss_pkg.
module ipss_finish (
  input  ipss_pkg::ipss_terms_t               terms,
  output logic signed [ipss_pkg::OUT_W-1:0]   result
);
  import ipss_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] mag;
  logic signed [SUM_W-1:0] quot;
  logic signed [SUM_W-1:0] total;

  always_comb begin
    sum = SUM_W'(terms.prod_p) + SUM_W'(terms.prod_i) + SUM_W'(terms.prod_d);
    mag = sum[SUM_W-1] ? -sum : sum;
    quot = mag >>> GAIN_FRAC_BITS;
    if (sum[SUM_W-1]) begin
      quot = -quot;
    end
    total = quot + SUM_W'(terms.offset);
    if (terms.clear) begin
      result = '0;
    end else if (total > SAT_MAX) begin
      result = OUT_W'(SAT_MAX);
    end else if (total < SAT_MIN) begin
      result = OUT_W'(SAT_MIN);
    end else begin
      result = OUT_W'(total);
    end
  end

endmodule

[rtl/core/incremental_pid_speed_step_core.sv]
// Top level of the incremental PID speed step core.
// Holds the configuration registers and the input, middle and result registers.
// Depends on ipss_pkg, ipss_terms and ipss_finish.
//
// Usage: an item (operation, measured_speed, target_speed) enters on the
// item_valid/item_ready handshake and yields exactly one drive_increment on
// the result_valid/result_ready handshake. A clear item zeroes the stored
// errors, last speed and boost flag and returns zero.
// Throughput: one item per cycle while the receiver does not stall; the
// stages are the input register, the gain product register and the result
// register.
// Configuration must be written through cfg_write_enable, cfg_index and
// cfg_data only while no item is in flight; the block does not enforce this. Unknown indexes are ignored.
// Reset clears all pipeline valids and the controller state and restores
// the default gains and mode.
// When the receiver stalls, the result register holds its item and the
// stages behind it keep filling; item_ready drops once all three are full.
module incremental_pid_speed_step_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                operation,
  input  logic signed [ipss_pkg::SPEED_W-1:0] measured_speed,
  input  logic signed [ipss_pkg::SPEED_W-1:0] target_speed,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [ipss_pkg::OUT_W-1:0]   drive_increment,
  input  logic                                cfg_write_enable,
  input  logic [ipss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipss_pkg::GAIN_W-1:0]         cfg_data
);
  import ipss_pkg::*;

  logic                      loop_mode;
  logic [GAIN_W-1:0]         proportional_gain;
  logic [GAIN_W-1:0]         integral_gain;
  logic [GAIN_W-1:0]         derivative_gain;

  logic                      in_full;
  logic                      op_q;
  logic signed [SPEED_W-1:0] meas_q;
  logic signed [SPEED_W-1:0] targ_q;

  logic                      mid_full;
  ipss_terms_t               mid_q;
  ipss_terms_t               terms;

  logic signed [OUT_W-1:0]   result_next;

  logic                      out_open;
  logic                      mid_open;
  logic                      in_move;

  assign out_open   = !result_valid || result_ready;
  assign mid_open   = !mid_full || out_open;
  assign in_move    = in_full && mid_open;
  assign item_ready = !in_full || mid_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_mode         <= MODE_PID;
      proportional_gain <= PROP_GAIN_RESET;
      integral_gain     <= INT_GAIN_RESET;
      derivative_gain   <= DER_GAIN_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_LOOP_MODE: loop_mode         <= cfg_data[0];
        REG_PROP_GAIN: proportional_gain <= cfg_data;
        REG_INT_GAIN:  integral_gain     <= cfg_data;
        REG_DER_GAIN:  derivative_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      mid_full     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        in_full <= item_valid;
      end
      if (mid_open) begin
        mid_full <= in_full;
      end
      if (out_open) begin
        result_valid <= mid_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      op_q   <= operation;
      meas_q <= measured_speed;
      targ_q <= target_speed;
    end
    if (in_move) begin
      mid_q <= terms;
    end
    if (out_open && mid_full) begin
      drive_increment <= result_next;
    end
  end

  ipss_terms u_terms (
    .clk               (clk),
    .rst               (rst),
    .advance           (in_move),
    .operation         (op_q),
    .measured_speed    (meas_q),
    .target_speed      (targ_q),
    .loop_mode         (loop_mode),
    .proportional_gain (proportional_gain),
    .integral_gain     (integral_gain),
    .derivative_gain   (derivative_gain),
    .terms             (terms)
  );

  ipss_finish u_finish (
    .terms  (mid_q),
    .result (result_next)
  );

endmodule

[test/incremental_pid_speed_step_core_tb.sv]
// Self-checking testbench for incremental_pid_speed_step_core.
// A built-in predictor of the speed regulator checks every drive increment
// under random idling; it depends on ipss_pkg and the core RTL.
`timescale 1ns / 1ps

module incremental_pid_speed_step_core_tb;
  import ipss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SPEED_MIN = -32768;
  localparam int SPEED_MAX = 32767;

  typedef struct {
    logic                      op;
    logic signed [SPEED_W-1:0] meas;
    logic signed [SPEED_W-1:0] targ;
  } speed_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic operation = OP_STEP;
  logic signed [SPEED_W-1:0] measured_speed = '0;
  logic signed [SPEED_W-1:0] target_speed = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [OUT_W-1:0] drive_increment;
  logic cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOOP_MODE;
  logic [GAIN_W-1:0] cfg_data = '0;

  speed_sample_t samples_queued[$];
  logic signed [OUT_W-1:0] increments_due[$];
  logic item_fire = 1'b0;
  logic steady = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  int drift_speed = 0;

  logic mode_q = MODE_PID;
  logic [GAIN_W-1:0] kp_q = PROP_GAIN_RESET;
  logic [GAIN_W-1:0] ki_q = INT_GAIN_RESET;
  logic [GAIN_W-1:0] kd_q = DER_GAIN_RESET;
  logic signed [ERR_W-1:0] err_z1 = '0;
  logic signed [ERR_W-1:0] err_z2 = '0;
  logic signed [SPEED_W-1:0] speed_z1 = '0;
  logic boost_armed = 1'b0;

  incremental_pid_speed_step_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .operation(operation),
    .measured_speed(measured_speed),
    .target_speed(target_speed),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .drive_increment(drive_increment),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [OUT_W-1:0] step_regulator(speed_sample_t s);
    longint err;
    longint d2;
    longint acc;
    longint whole;
    longint bias;
    bias = 0;
    if (s.op == OP_CLEAR) begin
      err_z1 = '0;
      err_z2 = '0;
      speed_z1 = '0;
      boost_armed = 1'b0;
      return '0;
    end
    err = longint'(s.targ) - longint'(s.meas);
    d2 = err - 2 * longint'(err_z1) + longint'(err_z2);
    if (mode_q == MODE_PID) begin
      acc = longint'(kp_q) * (err - longint'(err_z1)) + longint'(ki_q) * err
          + longint'(kd_q) * d2;
      if (err < -70) begin
        boost_armed = 1'b1;
        bias = -80;
      end else if (err < -50) begin
        boost_armed = 1'b1;
        bias = -50;
      end else if (err < -30) begin
        boost_armed = 1'b1;
        bias = -20;
      end
      if (err > 50) begin
        if (boost_armed) begin
          boost_armed = 1'b0;
          bias = bias + 170;
        end else begin
          bias = bias + 120;
        end
      end
    end else begin
      acc = -(longint'(kp_q) * (longint'(s.meas) - longint'(speed_z1)))
          + longint'(ki_q) * err + longint'(kd_q) * d2;
      speed_z1 = s.meas;
      if (err < -100) bias = -400;
      else if (err < -80) bias = -300;
      else if (err < -50) bias = -250;
      else if (err < -30) bias = -200;
    end
    err_z2 = err_z1;
    err_z1 = err[ERR_W-1:0];
    // Division truncates toward zero, which is the rounding the block uses.
    whole = acc / (longint'(1) << GAIN_FRAC_BITS) + bias;
    if (whole > 64'sd2147483647) whole = 64'sd2147483647;
    if (whole < -64'sd2147483648) whole = -64'sd2147483648;
    return whole[OUT_W-1:0];
  endfunction

  function automatic speed_sample_t random_sample();
    speed_sample_t s;
    logic [31:0] r;
    int pick;
    int t;
    pick = $urandom_range(99);
    r = $urandom;
    s.op = (pick < 5) ? OP_CLEAR : OP_STEP;
    if (pick < 40) begin
      drift_speed = int'($signed(r[15:0]));
    end else begin
      drift_speed = drift_speed + int'($urandom_range(400)) - 200;
      if (drift_speed > SPEED_MAX) drift_speed = SPEED_MAX;
      if (drift_speed < SPEED_MIN) drift_speed = SPEED_MIN;
    end
    s.meas = drift_speed[15:0];
    if (pick < 25) begin
      t = int'($signed(r[31:16]));
    end else begin
      t = drift_speed + int'($urandom_range(300)) - 150;
      if (t > SPEED_MAX) t = SPEED_MAX;
      if (t < SPEED_MIN) t = SPEED_MIN;
    end
    s.targ = t[15:0];
    return s;
  endfunction

  task automatic push_step(int meas, int targ);
    speed_sample_t s;
    s.op = OP_STEP;
    s.meas = meas[15:0];
    s.targ = targ[15:0];
    samples_queued.push_back(s);
  endtask

  task automatic push_clear();
    speed_sample_t s;
    s.op = OP_CLEAR;
    s.meas = '0;
    s.targ = '0;
    samples_queued.push_back(s);
  endtask

  task automatic wait_drained();
    while (samples_queued.size() != 0 || item_valid || increments_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    @(negedge clk);
    cfg_write_enable = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_LOOP_MODE: mode_q = data[0];
      REG_PROP_GAIN: kp_q = data;
      REG_INT_GAIN: ki_q = data;
      REG_DER_GAIN: kd_q = data;
      default: ;
    endcase
  endtask

  task automatic set_gains(logic mode, logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                           logic [GAIN_W-1:0] kd);
    write_reg(REG_LOOP_MODE, {{(GAIN_W-1){1'b0}}, mode});
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INT_GAIN, ki);
    write_reg(REG_DER_GAIN, kd);
    @(negedge clk);
    cfg_write_enable = 1'b0;
  endtask

  task automatic run_random(int count);
    repeat (count) samples_queued.push_back(random_sample());
    wait_drained();
  endtask

  always @(negedge clk) begin
    speed_sample_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (samples_queued.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
        nxt = samples_queued.pop_front();
        item_valid <= 1'b1;
        operation <= nxt.op;
        measured_speed <= nxt.meas;
        target_speed <= nxt.targ;
      end else begin
        item_valid <= 1'b0;
      end
    end
    result_ready <= steady || $urandom_range(99) >= 6;
  end

  always @(posedge clk) begin
    speed_sample_t seen;
    logic signed [OUT_W-1:0] want;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    item_fire <= !rst && item_valid && item_ready;
    if (!rst && item_valid && item_ready) begin
      seen.op = operation;
      seen.meas = measured_speed;
      seen.targ = target_speed;
      increments_due.push_back(step_regulator(seen));
    end
    if (!rst && result_valid && result_ready) begin
      if (increments_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected drive_increment %0d at cycle %0d", drive_increment, cycles);
      end else begin
        want = increments_due.pop_front();
        if (drive_increment !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive_increment mismatch at cycle %0d: expected %0d, got %0d",
                     cycles, want, drive_increment);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset gains in the plain loop: band edges, boost set and then spent.
    push_clear();
    push_step(0, 0);
    push_step(SPEED_MIN, SPEED_MAX);
    push_step(SPEED_MAX, SPEED_MIN);
    push_step(71, 0);
    push_step(70, 0);
    push_step(51, 0);
    push_step(31, 0);
    push_step(30, 0);
    push_step(0, 51);
    push_step(0, 51);
    push_step(0, 50);
    wait_drained();

    // Damped loop: its stepped offsets, a large acceleration and a clear.
    set_gains(MODE_DAMP, PROP_GAIN_RESET, INT_GAIN_RESET, 16'd300);
    push_step(101, 0);
    push_step(100, 0);
    push_step(81, 0);
    push_step(80, 0);
    push_step(50, 0);
    push_step(31, 0);
    push_step(30, 0);
    push_step(SPEED_MAX, SPEED_MIN);
    push_step(SPEED_MIN, SPEED_MAX);
    push_clear();
    wait_drained();

    set_gains(MODE_PID, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(80);
    set_gains(MODE_DAMP, 16'h0000, 16'h0000, 16'h0000);
    run_random(60);
    steady = 1'b1;
    set_gains(MODE_PID, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)));
    run_random(120);
    steady = 1'b0;
    set_gains(MODE_DAMP, 16'hFFFF, 16'($urandom_range(65535)),
              16'($urandom_range(65535)));
    run_random(120);
    set_gains(MODE_PID, 16'($urandom_range(2047)), 16'($urandom_range(2047)),
              16'($urandom_range(2047)));
    run_random(120);

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
